FILE: rtl/stt_pkg.sv
// Shared types, codes and helpers of the software timer table.
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned TIMERS_DEFAULT = 16;

  localparam logic [1:0] OP_SCHEDULE = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [1:0] KIND_ASSIGNED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_FIRED    = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] due_time;
    logic [23:0] period;
    logic        rep;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic  keep;
    logic  fire;
    slot_t slot;
  } verdict_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/stt_slot_eval.sv
// Keep, fire and rearm decision for one table slot during a scan.
`timescale 1ns / 1ps
module stt_slot_eval (
  input  logic             cancel_mode,
  input  logic [31:0]      time_now,
  input  logic [31:0]      cancel_id,
  input  stt_pkg::slot_t   slot,
  output stt_pkg::verdict_t verdict
);

  always_comb begin
    verdict.slot = slot;
    verdict.fire = 1'b0;
    verdict.keep = 1'b1;
    if (cancel_mode) begin
      verdict.keep = (slot.id != cancel_id);
    end else if (time_now >= slot.due_time) begin
      verdict.fire = 1'b1;
      if (slot.rep && (slot.period != '0)) begin
        verdict.slot.due_time = stt_pkg::sat_add(time_now, {8'd0, slot.period});
      end else begin
        verdict.keep = 1'b0;
      end
    end
  end

endmodule

FILE: rtl/software_timer_table_core.sv
// Top level of the software timer table: control sequencer, slot RAM and result register.
// Schedule and undefined operations: result registered in S_FIN once the result register is free.
// Cancel and tick: one RAM read per slot, pipelined, over all N entries;
// a tick stalls a slot while a fired word waits on a full result register.
// One item is in work at a time; the next is taken once the final result is registered.
// Reset: synchronous; clears the count, last tick time (0) and id counter (1), no RAM sweep.
`timescale 1ns / 1ps
module software_timer_table_core #(
  parameter int unsigned TIMERS = stt_pkg::TIMERS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] time_now,
  input  logic [23:0] delay,
  input  logic [23:0] period,
  input  logic        repeating,
  input  logic [31:0] cancel_id,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  kind,
  output logic [31:0] timer_tag,
  output logic        matched,
  output logic        last
);

  localparam int unsigned IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned CW = $clog2(TIMERS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t      state;
  logic [1:0]  cur_op;
  logic [31:0] cur_time;
  logic [23:0] cur_delay;
  logic [23:0] cur_period;
  logic        cur_rep;
  logic [31:0] cur_cid;

  logic [CW-1:0] entry_count;
  logic [31:0]   last_tick_time;
  logic [31:0]   next_id;

  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] wr_cnt;
  logic          ev_valid;
  logic          hit;
  logic          pend_valid;
  logic [31:0]   pend_id;

  logic                       out_free;
  logic                       stall;
  logic                       advance;
  logic                       issue;
  logic                       scan_done;
  logic                       table_full;
  logic                       scan_write;
  logic                       sched_write;
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [stt_pkg::SLOT_W-1:0] ram_wdata;
  logic [stt_pkg::SLOT_W-1:0] ram_rdata;
  stt_pkg::slot_t             ev_slot;
  stt_pkg::slot_t             new_slot;
  stt_pkg::verdict_t          verdict;

  logic        out_load;
  logic [1:0]  kind_next;
  logic [31:0] timer_tag_next;
  logic        matched_next;
  logic        last_next;

  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign table_full = (entry_count >= CW'(TIMERS));
  assign ev_slot    = stt_pkg::slot_t'(ram_rdata);

  stt_slot_eval u_eval (
    .cancel_mode (cur_op == stt_pkg::OP_CANCEL),
    .time_now    (cur_time),
    .cancel_id   (cur_cid),
    .slot        (ev_slot),
    .verdict     (verdict)
  );

  assign stall     = ev_valid && verdict.fire && pend_valid && !out_free;
  assign advance   = (state == S_SCAN) && !stall;
  assign issue     = advance && (rd_cnt < entry_count);
  assign scan_done = (state == S_SCAN) && !ev_valid && (rd_cnt == entry_count);

  always_comb begin
    new_slot.id       = next_id;
    new_slot.due_time = stt_pkg::sat_add(last_tick_time, {8'd0, cur_delay});
    new_slot.period   = cur_period;
    new_slot.rep      = cur_rep;
  end

  assign scan_write  = advance && ev_valid && verdict.keep;
  assign sched_write = (state == S_FIN) && (cur_op == stt_pkg::OP_SCHEDULE) && out_free &&
                       !table_full;
  assign ram_we      = scan_write || sched_write;
  assign ram_waddr   = scan_write ? wr_cnt[IW-1:0] : entry_count[IW-1:0];
  assign ram_wdata   = scan_write ? verdict.slot : new_slot;

  stt_ram #(
    .WIDTH (stt_pkg::SLOT_W),
    .DEPTH (TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_cnt[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_load       = 1'b0;
    kind_next      = stt_pkg::KIND_DONE;
    timer_tag_next = '0;
    matched_next   = 1'b0;
    last_next      = 1'b1;
    if (advance && ev_valid && verdict.fire && pend_valid) begin
      out_load       = 1'b1;
      kind_next      = stt_pkg::KIND_FIRED;
      timer_tag_next = pend_id;
      last_next      = 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_load = 1'b1;
      unique case (cur_op)
        stt_pkg::OP_SCHEDULE: begin
          if (table_full) begin
            kind_next = stt_pkg::KIND_FULL;
          end else begin
            kind_next      = stt_pkg::KIND_ASSIGNED;
            timer_tag_next = next_id;
          end
        end
        stt_pkg::OP_CANCEL: begin
          matched_next = hit;
        end
        stt_pkg::OP_TICK: begin
          if (pend_valid) begin
            kind_next      = stt_pkg::KIND_FIRED;
            timer_tag_next = pend_id;
          end
        end
        default: begin
          kind_next = stt_pkg::KIND_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      entry_count    <= '0;
      last_tick_time <= '0;
      next_id        <= 32'd1;
      rd_cnt         <= '0;
      wr_cnt         <= '0;
      ev_valid       <= 1'b0;
      hit            <= 1'b0;
      pend_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
        kind         <= kind_next;
        timer_tag    <= timer_tag_next;
        matched      <= matched_next;
        last         <= last_next;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur_op     <= operation;
            cur_time   <= time_now;
            cur_delay  <= delay;
            cur_period <= period;
            cur_rep    <= repeating;
            cur_cid    <= cancel_id;
            rd_cnt     <= '0;
            wr_cnt     <= '0;
            ev_valid   <= 1'b0;
            hit        <= 1'b0;
            pend_valid <= 1'b0;
            if (operation == stt_pkg::OP_TICK) begin
              last_tick_time <= time_now;
            end
            if ((operation == stt_pkg::OP_CANCEL) || (operation == stt_pkg::OP_TICK)) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            entry_count <= wr_cnt;
            state       <= S_FIN;
          end else if (advance) begin
            ev_valid <= issue;
            if (issue) begin
              rd_cnt <= rd_cnt + CW'(1);
            end
            if (ev_valid) begin
              if (verdict.keep) begin
                wr_cnt <= wr_cnt + CW'(1);
              end else begin
                hit <= 1'b1;
              end
              if (verdict.fire) begin
                pend_valid <= 1'b1;
                pend_id    <= ev_slot.id;
              end
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (sched_write) begin
              entry_count <= entry_count + CW'(1);
              next_id     <= next_id + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TIMERS))
    else $error("entry count above table size");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && ram_we) |-> (wr_cnt < rd_cnt))
    else $error("compaction write overtook the read pointer");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_load && kind_next == stt_pkg::KIND_FULL) |-> (entry_count == CW'(TIMERS)))
    else $error("full word with free slots");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> ($stable(rd_cnt) && $stable(wr_cnt)))
    else $error("scan pointers moved during a stall");

endmodule
